>>> design/rhcb_pkg.sv
package rhcb_pkg;

    localparam int BYTE_W = 8;
    localparam int HASH_W = 30;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [HASH_W-1:0] HASH_BASE  = 30'd3;
    localparam logic [HASH_W-1:0] MASK_RESET = 30'h1fff;

    // Register index sits at paddr[2]; low address bits are ignored.
    localparam logic REG_BOUNDARY_MASK = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              stream_last;
    } rhcb_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              chunk_end;
        logic              anchor_hit;
        logic [HASH_W-1:0] fingerprint;
        logic              window_full;
    } rhcb_out_t;

    // HASH_BASE^n modulo 2^HASH_W, evaluated at elaboration.
    function automatic logic [HASH_W-1:0] base_power(input int n);
        logic [2*HASH_W-1:0] p;
        p = '0;
        p[0] = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            p = {{HASH_W{1'b0}}, p[HASH_W-1:0]} * {{HASH_W{1'b0}}, HASH_BASE};
        end
        return p[HASH_W-1:0];
    endfunction

endpackage

>>> design/rhcb_stream_if.sv
interface rhcb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/rolling_hash_chunk_boundary_top.sv
// Content-defined chunk boundary finder. Every input byte comes out unchanged in the next cycle
// with a 30-bit rolling fingerprint (base 3, modulo 2^30) of the last WINDOW_BYTES bytes and
// chunk flags. A chunk ends where the window is full and the fingerprint bits selected by
// boundary_mask (APB register 0, reset 0x1fff) are all zero, or at the stream's last byte;
// the window then restarts empty. One byte is taken every clock while the output is not stalled:
// the fingerprint update (times three, minus the departing byte times 3^WINDOW_BYTES, plus the
// new byte) closes around the fingerprint register, through one 8x30 multiplier.
// The output register lets a new byte in while the previous result is being taken.
module rolling_hash_chunk_boundary_top #(
    parameter int WINDOW_BYTES = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rhcb_stream_if.sink                        in_stream,
    rhcb_stream_if.source                      out_stream,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rhcb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rhcb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rhcb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import rhcb_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_BYTES);
    localparam logic [HASH_W-1:0] BASE_POW = base_power(WINDOW_BYTES);

    logic [HASH_W-1:0] mask_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [BYTE_W-1:0] win_reg [WINDOW_BYTES];
    rhcb_out_t         out_reg;
    rhcb_out_t         out_next;
    logic              out_valid_reg;

    logic                     accept;
    logic                     cfg_write;
    logic [BYTE_W-1:0]        departing;
    logic [HASH_W+BYTE_W-1:0] drop_prod;
    logic [HASH_W-1:0]        hash_x3;
    logic [HASH_W-1:0]        hash_calc;
    logic [FILL_W-1:0]        fill_inc;
    logic                     full;
    logic                     anchor;
    logic                     chunk_end;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_BOUNDARY_MASK)
        begin
            prdata = {{(APB_DATA_W-HASH_W){1'b0}}, mask_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_write && paddr[2] == REG_BOUNDARY_MASK)
        begin
            mask_reg <= pwdata[HASH_W-1:0];
        end
    end

    // Stream handshake: one output register, refilled in the cycle it drains
    assign in_stream.ready    = !out_valid_reg || out_stream.ready;
    assign accept             = in_stream.valid && in_stream.ready;
    assign out_stream.valid   = out_valid_reg;
    assign out_stream.payload = out_reg;

    // Fingerprint update
    always_comb
    begin
        departing = (fill_reg == FILL_MAX) ? win_reg[0] : '0;
        drop_prod = {{HASH_W{1'b0}}, departing} * {{BYTE_W{1'b0}}, BASE_POW};
        hash_x3   = {hash_reg[HASH_W-2:0], 1'b0} + hash_reg;
        hash_calc = hash_x3 - drop_prod[HASH_W-1:0]
                    + {{(HASH_W-BYTE_W){1'b0}}, in_stream.payload.data_byte};

        fill_inc  = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + FILL_W'(1);
        full      = (fill_inc == FILL_MAX);
        anchor    = full && ((hash_calc & mask_reg) == '0);
        chunk_end = anchor || in_stream.payload.stream_last;

        // restart the window after any chunk end
        hash_next = chunk_end ? '0 : hash_calc;
        fill_next = chunk_end ? '0 : fill_inc;

        out_next.byte_out    = in_stream.payload.data_byte;
        out_next.chunk_end   = chunk_end;
        out_next.anchor_hit  = anchor;
        out_next.fingerprint = hash_calc;
        out_next.window_full = full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                hash_reg <= hash_next;
                fill_reg <= fill_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: window shift line and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < WINDOW_BYTES - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WINDOW_BYTES-1] <= in_stream.payload.data_byte;
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill count above window size");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chunk_end) |=> (fill_reg == '0 && hash_reg == '0))
        else $error("window not restarted after chunk end");

    a_anchor_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.anchor_hit) |-> (out_reg.window_full && out_reg.chunk_end))
        else $error("anchor flagged without a full window");
`endif

endmodule
